FILE: rtl/fpa_pkg.sv
// shared types and constants for the single-precision adder
`default_nettype none
package fpa_pkg;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
  localparam logic [31:0] MANT_MASK = 32'h007f_ffff;
  localparam int unsigned MAX_GAP   = 25;

  typedef struct packed {
    logic [31:0] operand_b;
    logic [31:0] operand_a;
  } fpa_in_t;

  typedef struct packed {
    logic        range_flag;
    logic [31:0] sum_bits;
  } fpa_out_t;
endpackage
`default_nettype wire

FILE: rtl/float32_adder.sv
// top level of the single-precision adder
// s_axis carries operand pairs: tdata[31:0] operand_a, tdata[63:32] operand_b.
// m_axis carries results: tdata[31:0] sum_bits, tdata[32] range_flag.
// a request is registered at the input, computed by one combinational pass and
// captured in the result register when it is free; tvalid is that register's
// valid flag. throughput is one request per cycle, set by the single
// combinational pass, while the output does not stall.
// a stalled output holds the result; the input register advances only when it is
// empty or the result register is free or being drained, so no request is lost.
// reset clears both valid flags; payload registers are not reset.
// no nan, infinity or denormal handling; overflow gives infinity, underflow flushes.
`default_nettype none
module float32_adder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // operand_a, operand_b
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // sum_bits, range_flag, 7 zero bits
);
  import fpa_pkg::*;

  fpa_in_t  in_reg;
  logic     in_valid;
  fpa_out_t out_reg, core_res;
  logic     out_valid, out_free, in_free;

  fpa_core u_core (.req(in_reg), .res(core_res));

  assign out_free = !out_valid || m_axis_tready;
  assign in_free  = !in_valid || out_free;
  assign s_axis_tready = in_free;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_free) in_valid <= s_axis_tvalid;
      if (out_free) out_valid <= in_valid;
    end
    if (in_free && s_axis_tvalid) in_reg <= s_axis_tdata;
    if (out_free && in_valid) out_reg <= core_res;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_move: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_free |=> out_valid)
    else $error("request lost between stages");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("empty input stage not ready");
`endif
endmodule
`default_nettype wire

FILE: rtl/fpa_core.sv
// combinational align, add, normalize and round
`default_nettype none
module fpa_core (
  input  fpa_pkg::fpa_in_t  req,
  output fpa_pkg::fpa_out_t res
);
  import fpa_pkg::*;

  logic        sa, sb, fsign, pass, a_big;
  logic [7:0]  ea, eb, gap8;
  logic [29:0] siga, sigb, small_sig, big_sig, shifted, lostmask;
  logic        sticky;
  logic [31:0] total;
  logic [30:0] mag;
  logic [4:0]  lz;
  logic [30:0] norm;
  logic [24:0] rnd;
  logic        up, big;
  logic signed [10:0] fexp;
  logic [6:0]  st;

  always_comb begin
    sa = req.operand_a[31];
    sb = req.operand_b[31];
    ea = req.operand_a[30:23];
    eb = req.operand_b[30:23];
    a_big = ea > eb;
    gap8 = a_big ? ea - eb : eb - ea;
    pass = (gap8 > 8'(MAX_GAP)) || (req.operand_a == '0) || (req.operand_b == '0);
    siga = {1'b1, req.operand_a[22:0], 6'b0};
    sigb = {1'b1, req.operand_b[22:0], 6'b0};
    big_sig   = a_big ? siga : sigb;
    small_sig = a_big ? sigb : siga;
    // gap <= 25 here when used
    lostmask = ~(30'h3fff_ffff << gap8[4:0]);
    if (gap8 > 8'd29) lostmask = '1;
    sticky = |(small_sig & lostmask);
    shifted = (small_sig >> gap8[4:0]) | {29'b0, sticky};
    if (gap8 == 8'd0) shifted = small_sig;
    total = ((a_big ? sa : sb) ? -{2'b0, big_sig} : {2'b0, big_sig})
          + ((a_big ? sb : sa) ? -{2'b0, shifted} : {2'b0, shifted});
    fsign = total[31];
    mag = fsign ? 31'(-total) : total[30:0];
    lz = '0;
    for (int i = 0; i < 30; i++)
      if (mag[i]) lz = 5'(29 - i);
    norm = mag << lz;
    fexp = 11'({3'b0, (a_big ? ea : eb)});
    big = mag[30];
    if (big) begin
      st = mag[6:0];
      rnd = {1'b0, mag[30:7]};
      up = (st > 7'h40) || (st == 7'h40 && mag[7]);
      fexp = fexp + 11'sd1;
    end else begin
      st = {1'b0, norm[5:0]};
      rnd = {1'b0, norm[29:6]};
      up = (st > 7'h20) || (st == 7'h20 && norm[6]);
      fexp = fexp - 11'({6'b0, lz});
    end
    rnd = rnd + 25'(up);
    if (rnd[24]) begin
      rnd = rnd >> 1;
      fexp = fexp + 11'sd1;
    end
    res.range_flag = 1'b0;
    if (pass) begin
      res.sum_bits = a_big ? req.operand_a : req.operand_b;
    end else if (total == '0) begin
      res.sum_bits = '0;
    end else if (fexp >= 11'sd255) begin
      res.sum_bits = {fsign, 31'b0} | EXP_MASK;
      res.range_flag = 1'b1;
    end else if (fexp <= 11'sd0) begin
      res.sum_bits = {fsign, 31'b0};
      res.range_flag = 1'b1;
    end else begin
      res.sum_bits = {fsign, fexp[7:0], rnd[22:0]};
    end
  end
endmodule
`default_nettype wire
